// File: hw/rtl/bba_pkg.sv
// Shared types, constants and helper functions for the bitmap block arena allocator.
// Used by bba_bitmap_ram, bba_ctrl and the top level; depends on nothing else.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int NUM_BLOCKS      = 4;
    localparam int BLOCK_UNITS     = 4096;
    localparam int UNIT_BYTES      = 4;
    localparam int UNIT_SHIFT      = $clog2(UNIT_BYTES);
    localparam int WORD_BITS       = 64;
    localparam int WORDS_PER_BLOCK = BLOCK_UNITS / WORD_BITS;
    localparam int SLOT_W          = $clog2(NUM_BLOCKS);
    localparam int WIDX_W          = $clog2(WORDS_PER_BLOCK);
    localparam int BIT_W           = $clog2(WORD_BITS);
    localparam int ADDR_W          = SLOT_W + WIDX_W;
    localparam int MEM_DEPTH       = NUM_BLOCKS * WORDS_PER_BLOCK;
    localparam int UIDX_W          = $clog2(BLOCK_UNITS);
    localparam int CNT_W           = UIDX_W + 1;
    localparam int SIZE_W          = 14;
    localparam int PROD_W          = 15;

    localparam logic [CNT_W-1:0] FULL_BLOCK = CNT_W'(BLOCK_UNITS);

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_SETUP,
        S_RMW,
        S_FCHK,
        S_SCAN,
        S_FEND,
        S_DONE
    } t_state;

    typedef struct packed {
        t_req_kind         req_type;
        logic [SIZE_W-1:0] size_bytes;
        logic [1:0]        block_index;
        logic [13:0]       byte_offset;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [1:0]  result_block;
        logic [13:0] result_offset;
    } t_res;

    // Bits of one bitmap word whose unit index lies in [lo, hi).
    function automatic logic [WORD_BITS-1:0] range_mask(
        input logic [WIDX_W-1:0] word,
        input logic [CNT_W-1:0]  lo,
        input logic [CNT_W-1:0]  hi
    );
        logic [WORD_BITS-1:0] m;
        logic [CNT_W-1:0]     u;
        for (int i = 0; i < WORD_BITS; i++) begin
            u    = {1'b0, word, BIT_W'(i)};
            m[i] = (u >= lo) && (u < hi);
        end
        return m;
    endfunction

    // Position of the highest set bit.
    function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // Position of the lowest set bit.
    function automatic logic [BIT_W-1:0] bottom_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/bba_bitmap_ram.sv
// Used-unit bitmap storage: one write port and one read port with registered data.
// Depends on bba_pkg for its geometry.
`timescale 1ns / 1ps

module bba_bitmap_ram (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [bba_pkg::ADDR_W-1:0]                   i_waddr,
    input  logic [bba_pkg::WORD_BITS-1:0]                i_wdata,
    input  logic [bba_pkg::ADDR_W-1:0]                   i_raddr,
    output logic [bba_pkg::WORD_BITS-1:0]                o_rdata
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] r_mem [MEM_DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/bba_ctrl.sv
// Request sequencer: decodes a request, keeps the per-slot metadata and walks the
// bitmap memory word by word. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  bba_pkg::t_req                  i_req,
    input  logic                           i_res_free,
    output logic                           o_idle,
    output logic                           o_done,
    output bba_pkg::t_res                  o_res,
    output logic                           o_mem_we,
    output logic [bba_pkg::ADDR_W-1:0]     o_mem_waddr,
    output logic [bba_pkg::WORD_BITS-1:0]  o_mem_wdata,
    output logic [bba_pkg::ADDR_W-1:0]     o_mem_raddr,
    input  logic [bba_pkg::WORD_BITS-1:0]  i_mem_rdata
);
    import bba_pkg::*;

    t_state r_state, n_state;

    // Captured request
    t_req_kind         r_kind;
    logic [SIZE_W-1:0] r_size;
    logic [1:0]        r_blk;
    logic [13:0]       r_boff;
    logic [CNT_W-1:0]  r_units;
    logic [CNT_W-1:0]  r_off;
    logic [SLOT_W-1:0] r_slot;

    // Per-slot metadata
    logic [CNT_W-1:0]  r_seg_start [NUM_BLOCKS];
    logic [CNT_W-1:0]  r_seg_len   [NUM_BLOCKS];
    logic [CNT_W-1:0]  r_chunks    [NUM_BLOCKS];
    logic [CNT_W-1:0]  r_used      [NUM_BLOCKS];
    logic [PROD_W-1:0] r_prod      [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_live;
    logic [SLOT_W-1:0] r_act;
    logic              r_act_v;

    // Word walk
    logic [CNT_W-1:0]  r_lo, r_hi;
    logic [WIDX_W-1:0] r_rd_word, r_wr_word, r_last;
    logic              r_rd_go, r_wr_valid, r_set, r_up, r_back;
    t_res              r_res;

    // Decode helpers
    logic [CNT_W-1:0]  units_c;
    logic [CNT_W-1:0]  off_c;
    logic              alloc_bad, need_new, slot_found, free_bad;
    logic [SLOT_W-1:0] free_slot;
    logic [CNT_W-1:0]  cur_st, cur_ln, cur_end;
    logic [WORD_BITS-1:0] mask, masked;
    logic              found;
    logic [CNT_W-1:0]  p_back, p_fwd;
    logic              scan_end, back_go, fwd_go;

    assign units_c  = CNT_W'(({1'b0, r_size} + 15'(UNIT_BYTES - 1)) >> UNIT_SHIFT);
    assign off_c    = {1'b0, r_boff[13:UNIT_SHIFT]};
    assign cur_st   = r_seg_start[r_slot];
    assign cur_ln   = r_seg_len[r_slot];
    assign cur_end  = cur_st + cur_ln;
    assign mask     = range_mask(r_wr_word, r_lo, r_hi);
    assign masked   = i_mem_rdata & mask;
    assign found    = masked != '0;
    assign p_back   = found ? ({1'b0, r_wr_word, top_bit(masked)} + CNT_W'(1)) : '0;
    assign p_fwd    = found ? {1'b0, r_wr_word, bottom_bit(masked)} : FULL_BLOCK;
    assign scan_end = r_wr_valid && (found || (r_wr_word == r_last));
    assign back_go  = (r_hi == cur_st) && (cur_st != '0);
    assign fwd_go   = (r_off == cur_end);

    always_comb begin
        alloc_bad  = (r_size == '0) || (units_c >= FULL_BLOCK);
        need_new   = !r_act_v || (r_seg_len[r_act] < units_c);
        slot_found = 1'b0;
        free_slot  = '0;
        for (int s = NUM_BLOCKS - 1; s >= 0; s--) begin
            if (!r_live[s]) begin
                slot_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
        free_bad = (r_size == '0) || !r_live[r_blk] || (r_chunks[r_blk] == '0) ||
                   (r_boff[UNIT_SHIFT-1:0] != '0) || (units_c > (FULL_BLOCK - off_c));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_DECODE;
            S_DECODE: begin
                if (r_kind == REQ_ALLOC) begin
                    if (alloc_bad) n_state = S_DONE;
                    else if (need_new) n_state = slot_found ? S_CLEAR : S_DONE;
                    else n_state = S_SETUP;
                end else begin
                    n_state = free_bad ? S_DONE : S_RMW;
                end
            end
            S_CLEAR:  if (r_rd_word == WIDX_W'(WORDS_PER_BLOCK - 1)) n_state = S_SETUP;
            S_SETUP:  n_state = S_RMW;
            S_RMW: begin
                if (r_wr_valid && (r_wr_word == r_last)) begin
                    n_state = (r_kind == REQ_ALLOC) ? S_DONE : S_FCHK;
                end
            end
            S_FCHK:   n_state = (back_go || fwd_go) ? S_SCAN : S_FEND;
            S_SCAN:   if (scan_end) n_state = S_FEND;
            S_FEND:   n_state = S_DONE;
            S_DONE:   if (i_res_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs and memory control
    always_comb begin
        o_idle      = (r_state == S_IDLE);
        o_done      = (r_state == S_DONE) && i_res_free;
        o_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = {r_slot, r_wr_word};
        o_mem_wdata = r_set ? (i_mem_rdata | mask) : (i_mem_rdata & ~mask);
        o_mem_raddr = {r_slot, r_rd_word};
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = {r_slot, r_rd_word};
                o_mem_wdata = '0;
            end
            S_RMW:   o_mem_we = r_wr_valid;
            default: o_mem_we = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Metadata and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_BLOCKS; s++) begin
                r_seg_start[s] <= '0;
                r_seg_len[s]   <= FULL_BLOCK;
                r_chunks[s]    <= '0;
                r_used[s]      <= '0;
                r_prod[s]      <= '0;
            end
            r_live     <= '0;
            r_act      <= '0;
            r_act_v    <= 1'b0;
            r_rd_go    <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind <= i_req.req_type;
                        r_size <= i_req.size_bytes;
                        r_blk  <= i_req.block_index;
                        r_boff <= i_req.byte_offset;
                    end
                end
                S_DECODE: begin
                    r_units             <= units_c;
                    r_off               <= off_c;
                    r_wr_valid          <= 1'b0;
                    r_res.result_block  <= '0;
                    r_res.result_offset <= '0;
                    if (r_kind == REQ_ALLOC) begin
                        r_rd_word <= '0;
                        r_rd_go   <= 1'b0;
                        if (alloc_bad) begin
                            r_slot       <= r_act;
                            r_res.status <= ST_BAD;
                        end else if (need_new && !slot_found) begin
                            r_slot       <= r_act;
                            r_res.status <= ST_OOM;
                        end else if (need_new) begin
                            // Claim the lowest idle slot and reset its metadata.
                            r_res.status           <= ST_OK;
                            r_slot                 <= free_slot;
                            r_seg_start[free_slot] <= '0;
                            r_seg_len[free_slot]   <= FULL_BLOCK;
                            r_chunks[free_slot]    <= '0;
                            r_used[free_slot]      <= '0;
                            r_prod[free_slot]      <= '0;
                            r_live[free_slot]      <= 1'b1;
                            r_act                  <= free_slot;
                            r_act_v                <= 1'b1;
                        end else begin
                            r_slot       <= r_act;
                            r_res.status <= ST_OK;
                        end
                    end else begin
                        r_slot <= r_blk;
                        if (free_bad) begin
                            r_res.status <= ST_BAD;
                            r_rd_word    <= '0;
                            r_rd_go      <= 1'b0;
                        end else begin
                            r_res.status    <= ST_OK;
                            r_chunks[r_blk] <= r_chunks[r_blk] - CNT_W'(1);
                            r_used[r_blk]   <= (r_used[r_blk] > units_c) ?
                                               (r_used[r_blk] - units_c) : '0;
                            r_lo      <= off_c;
                            r_hi      <= off_c + units_c;
                            r_rd_word <= off_c[UIDX_W-1:BIT_W];
                            r_last    <= WIDX_W'((off_c + units_c - CNT_W'(1)) >> BIT_W);
                            r_set     <= 1'b0;
                            r_up      <= 1'b1;
                            r_rd_go   <= 1'b1;
                        end
                    end
                end
                S_CLEAR: begin
                    r_rd_word <= r_rd_word + WIDX_W'(1);
                end
                S_SETUP: begin
                    r_lo      <= cur_st;
                    r_hi      <= cur_st + r_units;
                    r_rd_word <= cur_st[UIDX_W-1:BIT_W];
                    r_last    <= WIDX_W'((cur_st + r_units - CNT_W'(1)) >> BIT_W);
                    r_set     <= 1'b1;
                    r_up      <= 1'b1;
                    r_rd_go   <= 1'b1;
                    r_wr_valid <= 1'b0;
                    r_seg_start[r_slot] <= cur_st + r_units;
                    r_seg_len[r_slot]   <= cur_ln - r_units;
                    r_used[r_slot]      <= r_used[r_slot] + r_units;
                    r_prod[r_slot]      <= r_prod[r_slot] + PROD_W'(r_size);
                    r_chunks[r_slot]    <= r_chunks[r_slot] + CNT_W'(1);
                    r_res.result_block  <= 2'(r_slot);
                    r_res.result_offset <= {cur_st[UIDX_W-1:0], UNIT_SHIFT'(0)};
                end
                S_RMW, S_SCAN: begin
                    // One read issued and one word consumed per cycle.
                    r_wr_valid <= r_rd_go;
                    r_wr_word  <= r_rd_word;
                    if ((r_state == S_SCAN && scan_end) ||
                        (r_rd_go && (r_rd_word == r_last))) begin
                        r_rd_go <= 1'b0;
                    end
                    if (r_rd_go && (r_rd_word != r_last)) begin
                        r_rd_word <= r_up ? (r_rd_word + WIDX_W'(1))
                                          : (r_rd_word - WIDX_W'(1));
                    end
                    if (r_state == S_SCAN && scan_end) begin
                        if (r_back) begin
                            r_seg_start[r_slot] <= p_back;
                            r_seg_len[r_slot]   <= cur_ln + (cur_st - p_back);
                        end else begin
                            r_seg_len[r_slot]   <= cur_ln + (p_fwd - r_off);
                        end
                    end
                end
                S_FCHK: begin
                    r_wr_valid <= 1'b0;
                    r_rd_go    <= 1'b1;
                    if (back_go) begin
                        // Walk down from the unit below the segment start.
                        r_back    <= 1'b1;
                        r_up      <= 1'b0;
                        r_lo      <= '0;
                        r_hi      <= cur_st;
                        r_rd_word <= WIDX_W'((cur_st - CNT_W'(1)) >> BIT_W);
                        r_last    <= '0;
                    end else begin
                        // Walk up from the freed run past the segment end.
                        r_back    <= 1'b0;
                        r_up      <= 1'b1;
                        r_lo      <= r_off;
                        r_hi      <= FULL_BLOCK;
                        r_rd_word <= r_off[UIDX_W-1:BIT_W];
                        r_last    <= WIDX_W'(WORDS_PER_BLOCK - 1);
                    end
                end
                S_FEND: begin
                    if (r_chunks[r_slot] == '0) begin
                        r_seg_start[r_slot] <= '0;
                        r_seg_len[r_slot]   <= FULL_BLOCK;
                        r_used[r_slot]      <= '0;
                        r_prod[r_slot]      <= '0;
                        if (!(r_act_v && (r_act == r_slot))) begin
                            r_live[r_slot] <= 1'b0;
                        end
                    end else begin
                        r_prod[r_slot] <= (r_prod[r_slot] > PROD_W'(r_size)) ?
                                          (r_prod[r_slot] - PROD_W'(r_size)) : '0;
                    end
                end
                S_DONE: begin
                    r_rd_go <= 1'b0;
                end
                default: begin
                    r_rd_go <= 1'b0;
                end
            endcase
        end
    end

    // The active segment never runs past the block end.
    a_seg_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_v |-> ({1'b0, r_seg_start[r_act]} + {1'b0, r_seg_len[r_act]}) <=
                    (CNT_W + 1)'(BLOCK_UNITS))
        else $error("active segment runs past the block end");

    // An allocation always lands in the live, active slot.
    a_alloc_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> r_live[r_slot] && r_act_v && (r_act == r_slot))
        else $error("allocation outside the active slot");

    // A free only reaches the merge step on a live slot.
    a_free_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCHK) |-> r_live[r_slot])
        else $error("free merge on an idle slot");

endmodule

// File: hw/rtl/bitmap_block_arena_allocator.sv
// Flow: a rejected request goes from decode straight to its result; an allocation walks
// the bitmap words it covers, after clearing every word of a newly claimed slot.
// A free walks the words it covers, then may walk further to merge free units into the segment.
// One request at a time; the bitmap memory, one word per cycle, sets the pace.
// Reset clears all slot metadata at once; bitmap words are cleared when a slot is claimed.
// Top level: handshake, result register, memory and sequencer. Depends on bba_pkg,
// bba_bitmap_ram and bba_ctrl.
`timescale 1ns / 1ps

module bitmap_block_arena_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [13:0] i_size_bytes,
    input  logic [1:0]  i_block_index,
    input  logic [13:0] i_byte_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [1:0]  o_result_block,
    output logic [13:0] o_result_offset
);
    import bba_pkg::*;

    t_req                 req;
    t_res                 res;
    logic                 start, idle, done, res_free;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
    logic                 r_out_valid;
    t_res                 r_out;

    // Input beat goes straight to the sequencer, which captures it.
    assign req        = '{req_type: t_req_kind'(i_req_type), size_bytes: i_size_bytes,
                          block_index: i_block_index, byte_offset: i_byte_offset};
    assign o_in_ready = idle;
    assign start      = i_in_valid && idle;
    assign res_free   = !r_out_valid || i_out_ready;

    bba_bitmap_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_res_free  (res_free),
        .o_idle      (idle),
        .o_done      (done),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Result register: holds a beat until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_result_block  = r_out.result_block;
    assign o_result_offset = r_out.result_offset;

    // A finished result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the bitmap block arena allocator: directed and random
// requests, a cycle-free predictor of the slot pool, and a result scoreboard.
// Depends on bba_pkg and bitmap_block_arena_allocator.
`timescale 1ns / 1ps

module tb;
    import bba_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 580;

    typedef struct {
        int slot;
        int boff;
        int size;
    } t_region;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = 1'b0;
    logic [13:0] size_bytes = '0;
    logic [1:0]  block_index = '0;
    logic [13:0] byte_offset = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [1:0]  result_block;
    logic [13:0] result_offset;

    // Predictor state: one unit bitmap and segment per slot, and the pool.
    bit [BLOCK_UNITS-1:0] unit_map [NUM_BLOCKS];
    int  seg_first [NUM_BLOCKS];
    int  seg_len   [NUM_BLOCKS];
    int  chunks    [NUM_BLOCKS];
    bit  in_use    [NUM_BLOCKS];
    int  newest_slot;
    bit  have_newest;

    t_req    pending_reqs [$];
    t_res    expected_results [$];
    t_region live_regions [$];
    int      errors = 0;
    int      beats_in = 0;
    int      beats_out = 0;
    int      quiet_cycles = 0;
    int      hold_count = 0;
    bit      hold_done = 1'b0;

    bitmap_block_arena_allocator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_size_bytes    (size_bytes),
        .i_block_index   (block_index),
        .i_byte_offset   (byte_offset),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .o_result_block  (result_block),
        .o_result_offset (result_offset)
    );

    always #5 clk = ~clk;

    // Works out the outcome of one request and updates the pool accordingly.
    function automatic t_res allocate_or_free(input t_req rq);
        t_res r;
        int   units, slot, first, off, p, k;
        bit   found;
        r = '{status: ST_OK, result_block: 2'd0, result_offset: 14'd0};
        units = (int'(rq.size_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
        if (rq.req_type == REQ_ALLOC) begin
            if (rq.size_bytes == 0 || units >= BLOCK_UNITS) begin
                r.status = ST_BAD;
                return r;
            end
            slot = newest_slot;
            if (!have_newest || seg_len[slot] < units) begin
                found = 1'b0;
                for (int s = NUM_BLOCKS - 1; s >= 0; s--) begin
                    if (!in_use[s]) begin
                        found = 1'b1;
                        slot = s;
                    end
                end
                if (!found) begin
                    r.status = ST_OOM;
                    return r;
                end
                unit_map[slot] = '0;
                seg_first[slot] = 0;
                seg_len[slot] = BLOCK_UNITS;
                chunks[slot] = 0;
                in_use[slot] = 1'b1;
                newest_slot = slot;
                have_newest = 1'b1;
            end
            first = seg_first[slot];
            for (int u = first; u < first + units; u++) unit_map[slot][u] = 1'b1;
            seg_first[slot] = first + units;
            seg_len[slot] -= units;
            chunks[slot]++;
            r.result_block = slot[1:0];
            r.result_offset = 14'(first * UNIT_BYTES);
            return r;
        end
        // Free: reject a zero size, an idle or empty slot, a misaligned offset or a run past the block end.
        slot = rq.block_index;
        off = int'(rq.byte_offset) / UNIT_BYTES;
        if (rq.size_bytes == 0 || !in_use[slot] || chunks[slot] == 0 ||
            (rq.byte_offset % UNIT_BYTES) != 0 || units > BLOCK_UNITS - off) begin
            r.status = ST_BAD;
            return r;
        end
        chunks[slot]--;
        for (int u = off; u < off + units; u++) unit_map[slot][u] = 1'b0;
        // A run ending at the segment start lets the segment grow backwards.
        if (off + units == seg_first[slot]) begin
            p = seg_first[slot];
            k = 0;
            while (p > 0 && !unit_map[slot][p-1]) begin
                p--;
                k++;
            end
            seg_first[slot] -= k;
            seg_len[slot] += k;
        end
        // A run starting at the segment end lets it grow forwards.
        if (off == seg_first[slot] + seg_len[slot]) begin
            p = off;
            while (p < BLOCK_UNITS && !unit_map[slot][p]) p++;
            seg_len[slot] += p - off;
        end
        if (chunks[slot] == 0) begin
            seg_first[slot] = 0;
            seg_len[slot] = BLOCK_UNITS;
            if (!(have_newest && newest_slot == slot)) in_use[slot] = 1'b0;
        end
        return r;
    endfunction

    // Idle percentage of each side for the current stretch of the run.
    function automatic int sender_idle_pct();
        if (beats_in < 200) return 8;
        if (beats_in < 400) return 62;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (beats_in < 200) return 62;
        if (beats_in < 400) return 8;
        return 0;
    endfunction

    function automatic t_req make_req(input bit is_free, input int sz, input int blk,
                                      input int boff);
        t_req rq;
        rq.req_type = is_free ? REQ_FREE : REQ_ALLOC;
        rq.size_bytes = 14'(sz);
        rq.block_index = 2'(blk);
        rq.byte_offset = 14'(boff);
        return rq;
    endfunction

    // Driver: presents queued requests and predicts each beat as it is taken.
    always @(posedge clk) begin
        t_res exp_r;
        if (rst_n && in_valid && in_ready) begin
            exp_r = allocate_or_free(make_req(req_type, size_bytes, block_index, byte_offset));
            expected_results.push_back(exp_r);
            if (req_type == REQ_ALLOC && exp_r.status == ST_OK)
                live_regions.push_back('{int'(exp_r.result_block),
                                        int'(exp_r.result_offset), int'(size_bytes)});
            beats_in++;
        end
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                t_req rq;
                rq = pending_reqs.pop_front();
                req_type <= rq.req_type;
                size_bytes <= rq.size_bytes;
                block_index <= rq.block_index;
                byte_offset <= rq.byte_offset;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    always @(posedge clk) begin
        if (!hold_done && beats_out == 300 && hold_count < HOLD_CYCLES) begin
            hold_count++;
            if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // Monitor: compares every result beat with the oldest prediction.
    always @(posedge clk) begin
        t_res exp_r;
        if (rst_n && out_valid && out_ready) begin
            beats_out++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d block=%0d offset=%0d",
                         $time, status, result_block, result_offset);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status || result_block !== exp_r.result_block ||
                    result_offset !== exp_r.result_offset) begin
                    $display({"%0t: mismatch expected status=%0d block=%0d offset=%0d,",
                              " got status=%0d block=%0d offset=%0d"},
                             $time, exp_r.status, exp_r.result_block, exp_r.result_offset,
                             status, result_block, result_offset);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int      pick, sz, roll;
        t_region reg_r;
        for (int s = 0; s < NUM_BLOCKS; s++) begin
            unit_map[s] = '0;
            seg_first[s] = 0;
            seg_len[s] = BLOCK_UNITS;
            chunks[s] = 0;
            in_use[s] = 1'b0;
        end
        newest_slot = 0;
        have_newest = 1'b0;

        // Directed: rejects, filling every slot, and emptying slots.
        pending_reqs.push_back(make_req(0, 0, 0, 0));
        pending_reqs.push_back(make_req(1, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 16381, 0, 0));
        pending_reqs.push_back(make_req(0, 16383, 3, 16383));
        pending_reqs.push_back(make_req(0, 16380, 0, 0));
        pending_reqs.push_back(make_req(0, 1, 0, 0));
        pending_reqs.push_back(make_req(0, 16380, 0, 0));
        pending_reqs.push_back(make_req(0, 16380, 0, 0));
        pending_reqs.push_back(make_req(0, 16380, 0, 0));
        pending_reqs.push_back(make_req(0, 4, 0, 0));
        pending_reqs.push_back(make_req(1, 4, 0, 2));
        pending_reqs.push_back(make_req(1, 16380, 1, 4));
        pending_reqs.push_back(make_req(1, 16380, 0, 0));
        pending_reqs.push_back(make_req(1, 4, 0, 16380));
        pending_reqs.push_back(make_req(1, 4, 0, 0));
        pending_reqs.push_back(make_req(1, 16380, 1, 0));
        pending_reqs.push_back(make_req(1, 16380, 2, 0));
        pending_reqs.push_back(make_req(1, 16380, 3, 0));
        pending_reqs.push_back(make_req(0, 8, 0, 0));
        pending_reqs.push_back(make_req(0, 12, 0, 0));
        pending_reqs.push_back(make_req(0, 5, 0, 0));
        pending_reqs.push_back(make_req(1, 5, 3, 20));
        pending_reqs.push_back(make_req(1, 12, 3, 8));
        pending_reqs.push_back(make_req(1, 8, 3, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // Directed entries were already counted against live regions by prediction.
        while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
        live_regions.delete();

        // Random: mostly allocations and well-formed frees, with some noise.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            while (pending_reqs.size() >= 2) @(posedge clk);
            roll = $urandom_range(0, 99);
            if (roll < 40 && live_regions.size() > 0) begin
                pick = $urandom_range(0, live_regions.size() - 1);
                reg_r = live_regions[pick];
                live_regions.delete(pick);
                if ($urandom_range(0, 9) == 0) reg_r.size = $urandom_range(1, 64);
                pending_reqs.push_back(make_req(1, reg_r.size, reg_r.slot, reg_r.boff));
            end else if (roll < 90) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) sz = $urandom_range(1, 256);
                else if (roll < 95) sz = $urandom_range(257, 4000);
                else sz = $urandom_range(4001, 16383);
                pending_reqs.push_back(make_req(0, sz, $urandom_range(0, 3),
                                                $urandom_range(0, 16383)));
            end else begin
                pending_reqs.push_back(make_req($urandom_range(0, 1), $urandom_range(0, 16383),
                                                $urandom_range(0, 3), $urandom_range(0, 16383)));
            end
        end

        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_bitmap_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bitmap_block_arena_allocator.sv
sim/tb.sv
